// ===== rtl/core/pbs_pkg.sv =====
package pbs_pkg;

   // Q3.12 signed value, Q0.16 unsigned value, exact Q3.12 x Q0.16 product
   typedef logic signed [15:0] q312_type;
   typedef logic [15:0]        q016_type;
   typedef logic signed [32:0] prod_type;

   typedef struct packed {
      q312_type z;
      q312_type y;
      q312_type x;
   } vec_type;

   typedef struct packed {
      prod_type z;
      prod_type y;
      prod_type x;
   } prod_vec_type;

   // control passed to each multiplier lane group
   typedef struct packed {
      logic en;
   } mul_ctrl_type;

   typedef enum logic [2:0] {
      REG_GRAVITY_X  = 3'd0,
      REG_GRAVITY_Y  = 3'd1,
      REG_GRAVITY_Z  = 3'd2,
      REG_DAMPING    = 3'd3,
      REG_WALL_LIMIT = 3'd4
   } reg_index_type;

   localparam q312_type GRAVITY_X_RESET  = 16'sd0;
   localparam q312_type GRAVITY_Y_RESET  = -16'sd13380;
   localparam q312_type GRAVITY_Z_RESET  = 16'sd0;
   localparam q016_type DAMPING_RESET    = 16'd62259;
   localparam logic [14:0] WALL_RESET    = 15'd4096;

   function automatic q312_type sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // (p + 2^15) >> 16 with floor
   function automatic logic signed [16:0] round_q16(input prod_type p);
      prod_type s;
      s = p + 33'sd32768;
      return s[32:16];
   endfunction

   function automatic q312_type neg_sat(input q312_type v);
      logic signed [17:0] e;
      e = {{2{v[15]}}, v};
      return sat16(-e);
   endfunction

   function automatic q312_type add_round(input q312_type v, input prod_type p);
      logic signed [16:0] r;
      r = round_q16(p);
      return sat16({{2{v[15]}}, v} + {r[16], r});
   endfunction

   function automatic q312_type sat_round(input prod_type p);
      logic signed [16:0] r;
      r = round_q16(p);
      return sat16({r[16], r});
   endfunction

endpackage

// ===== rtl/core/pbs_lane_mul.sv =====
module pbs_lane_mul (
   input  logic                  clock,
   input  pbs_pkg::mul_ctrl_type ctrl,
   input  pbs_pkg::vec_type      a,
   input  pbs_pkg::q016_type     b,
   output pbs_pkg::prod_vec_type p_ff
);
   import pbs_pkg::*;

   prod_vec_type      p_in;
   logic signed [16:0] b_s;

   // products are formed at the full 33-bit width of prod_type
   always_comb begin
      b_s    = $signed({1'b0, b});
      p_in.x = a.x * b_s;
      p_in.y = a.y * b_s;
      p_in.z = a.z * b_s;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         p_ff <= p_in;
      end
   end

endmodule

// ===== rtl/core/particle_bounce_step.sv =====
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  req_tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
//                                        radius, step_time; req_tlast: frame_end
// rsp       out   rsp_tvalid/rsp_tready  rsp_tdata: new_pos_x/y/z, new_vel_x/y/z;
//                                        rsp_tuser: bounced; rsp_tlast: frame_end_out
// csr       in    csr_we                 csr_addr, csr_wdata
//
// Six register stages: gravity multiply, velocity update and reflection,
// damping multiply, damping select, step multiply, position add.
// One request per cycle unless rsp stalls; rsp_tvalid is driven from the last stage's valid bit.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage holds only while it is full and the stage after it holds, so
// a stall on rsp fills the bubbles before req_tready drops.
module particle_bounce_step (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius[110:96], step_time[126:111], zero
   input  logic [127:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
   output logic [95:0]  rsp_tdata,
   // bounced
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import pbs_pkg::*;

   // configuration
   q312_type    gravity_x_ff, gravity_y_ff, gravity_z_ff;
   q016_type    damping_ff;
   logic [14:0] wall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_x_ff <= GRAVITY_X_RESET;
         gravity_y_ff <= GRAVITY_Y_RESET;
         gravity_z_ff <= GRAVITY_Z_RESET;
         damping_ff   <= DAMPING_RESET;
         wall_ff      <= WALL_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_GRAVITY_X:  gravity_x_ff <= csr_wdata;
            REG_GRAVITY_Y:  gravity_y_ff <= csr_wdata;
            REG_GRAVITY_Z:  gravity_z_ff <= csr_wdata;
            REG_DAMPING:    damping_ff   <= csr_wdata;
            REG_WALL_LIMIT: wall_ff      <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // stage control
   logic [6:1] valid_ff;
   logic [7:1] adv;

   always_comb begin
      adv[7] = rsp_tready;
      for (int k = 6; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) begin
            valid_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= 6; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_tready = adv[1];

   // request unpack
   vec_type     req_pos, req_vel;
   logic [14:0] req_radius;
   q016_type    req_dt;

   assign req_pos    = req_tdata[47:0];
   assign req_vel    = req_tdata[95:48];
   assign req_radius = req_tdata[110:96];
   assign req_dt     = req_tdata[126:111];

   // stage 1: gravity products, floor and wall position tests
   vec_type      grav;
   prod_vec_type gprod_ff;
   vec_type      pos1_ff, vel1_ff;
   q016_type     dt1_ff;
   logic         last1_ff, floor1_ff;
   logic [1:0]   wlo1_ff, whi1_ff;     // [0] x, [1] z
   logic         floor1_in;
   logic [1:0]   wlo1_in, whi1_in;
   logic signed [16:0] r17, w17, lo17, hi17, px17, py17, pz17;

   assign grav = '{z: gravity_z_ff, y: gravity_y_ff, x: gravity_x_ff};

   pbs_lane_mul u_grav (
      .clock (clock),
      .ctrl  ('{en: adv[1]}),
      .a     (grav),
      .b     (req_dt),
      .p_ff  (gprod_ff)
   );

   always_comb begin
      r17  = $signed({2'b00, req_radius});
      w17  = $signed({2'b00, wall_ff});
      lo17 = r17 - w17;
      hi17 = w17 - r17;
      px17 = {req_pos.x[15], req_pos.x};
      py17 = {req_pos.y[15], req_pos.y};
      pz17 = {req_pos.z[15], req_pos.z};
      floor1_in  = (py17 <= r17) && req_vel.y[15];
      wlo1_in[0] = px17 <= lo17;
      whi1_in[0] = px17 >= hi17;
      wlo1_in[1] = pz17 <= lo17;
      whi1_in[1] = pz17 >= hi17;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pos1_ff   <= req_pos;
         vel1_ff   <= req_vel;
         dt1_ff    <= req_dt;
         last1_ff  <= req_tlast;
         floor1_ff <= floor1_in;
         wlo1_ff   <= wlo1_in;
         whi1_ff   <= whi1_in;
      end
   end

   // stage 2: floor bounce or gravity, then wall reflection
   vec_type  vel2_in, vel2_ff, pos2_ff;
   q016_type dt2_ff;
   logic     last2_ff, bounce2_ff, bounce2_in;
   logic     refl_x, refl_z;

   always_comb begin
      if (floor1_ff) begin
         vel2_in.x = vel1_ff.x;
         vel2_in.y = neg_sat(vel1_ff.y);
         vel2_in.z = vel1_ff.z;
      end else begin
         vel2_in.x = add_round(vel1_ff.x, gprod_ff.x);
         vel2_in.y = add_round(vel1_ff.y, gprod_ff.y);
         vel2_in.z = add_round(vel1_ff.z, gprod_ff.z);
      end
      refl_x = (wlo1_ff[0] && vel2_in.x < 0) || (whi1_ff[0] && vel2_in.x > 0);
      refl_z = (wlo1_ff[1] && vel2_in.z < 0) || (whi1_ff[1] && vel2_in.z > 0);
      if (refl_x) begin
         vel2_in.x = neg_sat(vel2_in.x);
      end
      if (refl_z) begin
         vel2_in.z = neg_sat(vel2_in.z);
      end
      bounce2_in = floor1_ff || refl_x || refl_z;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         vel2_ff    <= vel2_in;
         pos2_ff    <= pos1_ff;
         dt2_ff     <= dt1_ff;
         last2_ff   <= last1_ff;
         bounce2_ff <= bounce2_in;
      end
   end

   // stage 3: damping products
   prod_vec_type dprod_ff;
   vec_type      vel3_ff, pos3_ff;
   q016_type     dt3_ff;
   logic         last3_ff, bounce3_ff;

   pbs_lane_mul u_damp (
      .clock (clock),
      .ctrl  ('{en: adv[3]}),
      .a     (vel2_ff),
      .b     (damping_ff),
      .p_ff  (dprod_ff)
   );

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         vel3_ff    <= vel2_ff;
         pos3_ff    <= pos2_ff;
         dt3_ff     <= dt2_ff;
         last3_ff   <= last2_ff;
         bounce3_ff <= bounce2_ff;
      end
   end

   // stage 4: take damped velocity only after a bounce
   vec_type  vel4_in, vel4_ff, pos4_ff;
   q016_type dt4_ff;
   logic     last4_ff, bounce4_ff;

   always_comb begin
      if (bounce3_ff) begin
         vel4_in.x = sat_round(dprod_ff.x);
         vel4_in.y = sat_round(dprod_ff.y);
         vel4_in.z = sat_round(dprod_ff.z);
      end else begin
         vel4_in = vel3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         vel4_ff    <= vel4_in;
         pos4_ff    <= pos3_ff;
         dt4_ff     <= dt3_ff;
         last4_ff   <= last3_ff;
         bounce4_ff <= bounce3_ff;
      end
   end

   // stage 5: displacement products
   prod_vec_type sprod_ff;
   vec_type      vel5_ff, pos5_ff;
   logic         last5_ff, bounce5_ff;

   pbs_lane_mul u_step (
      .clock (clock),
      .ctrl  ('{en: adv[5]}),
      .a     (vel4_ff),
      .b     (dt4_ff),
      .p_ff  (sprod_ff)
   );

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         vel5_ff    <= vel4_ff;
         pos5_ff    <= pos4_ff;
         last5_ff   <= last4_ff;
         bounce5_ff <= bounce4_ff;
      end
   end

   // stage 6: advance position, output register
   vec_type pos6_in, pos6_ff, vel6_ff;
   logic    last6_ff, bounce6_ff;

   always_comb begin
      pos6_in.x = add_round(pos5_ff.x, sprod_ff.x);
      pos6_in.y = add_round(pos5_ff.y, sprod_ff.y);
      pos6_in.z = add_round(pos5_ff.z, sprod_ff.z);
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         pos6_ff    <= pos6_in;
         vel6_ff    <= vel5_ff;
         last6_ff   <= last5_ff;
         bounce6_ff <= bounce5_ff;
      end
   end

   assign rsp_tvalid = valid_ff[6];
   assign rsp_tdata  = {vel6_ff, pos6_ff};
   assign rsp_tuser  = bounce6_ff;
   assign rsp_tlast  = last6_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("request refused while a stage is empty");

   a_floor_up: assert property (@(posedge clock) disable iff (reset)
      adv[2] && valid_ff[1] && floor1_ff |=> bounce2_ff && !vel2_ff.y[15])
      else $error("floor bounce left vertical velocity negative");

   a_no_damp: assert property (@(posedge clock) disable iff (reset)
      adv[4] && valid_ff[3] && !bounce3_ff |=> vel4_ff == $past(vel3_ff))
      else $error("velocity damped without a bounce");
`endif

endmodule
